// File: design/cst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_pkg
// shared types and constants of the csv stream tokenizer
// ----------------------------------------------------------------------------
package cst_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [BYTE_W-1:0] QUOTE_BYTE     = 8'h22;
  localparam logic [BYTE_W-1:0] CR_BYTE        = 8'h0D;
  localparam logic [BYTE_W-1:0] LF_BYTE        = 8'h0A;
  localparam logic [BYTE_W-1:0] DELIM_RESET    = 8'h2C;

  // word index of the delimiter register
  localparam logic REG_DELIMITER = 1'b0;

  typedef enum logic {
    CMD_TEXT = 1'b0,
    CMD_END  = 1'b1
  } cst_cmd_t;

  typedef enum logic [1:0] {
    KIND_BYTE     = 2'd0,
    KIND_CELL_END = 2'd1,
    KIND_ROW_END  = 2'd2
  } cst_kind_t;

  typedef struct packed {
    logic              valid;
    cst_kind_t         kind;
    logic [BYTE_W-1:0] cell_byte;
    logic              drop_row;
  } cst_res_t;

endpackage
`default_nettype wire

// File: design/csv_stream_tokenizer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// csv_stream_tokenizer
// streaming csv tokenizer: one text byte in, at most one token out
//
// input channel: in_valid / in_stall carry in_cmd (text byte or end of text)
// and in_text_byte. output channel: out_valid / out_stall carry out_kind
// (content byte, end of cell, end of cell and row), out_cell_byte and
// out_drop_row, which marks a blank row for the receiver to discard.
// the delimiter register sits at byte address 0 of the apb-style port and
// resets to a comma; write it only while the block is idle.
// a transfer accepted into the input register is decoded against the quote
// and cell flags, and its token is then registered in the result register;
// the block takes one item per cycle while in_stall is low.
// items that produce no token (such as opening quotes and carriage
// returns) still pass through the input register.
// reset clears the flags and both valid bits, so no token is pending.
// while out_stall is high the result holds; the input register then fills,
// and in_stall rises once a held item needs the occupied result register.
// ----------------------------------------------------------------------------
module csv_stream_tokenizer
  import cst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire cst_cmd_t              in_cmd,
  input  wire logic [BYTE_W-1:0]     in_text_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output cst_kind_t                  out_kind,
  output logic      [BYTE_W-1:0]     out_cell_byte,
  output logic                       out_drop_row,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  logic [BYTE_W-1:0] delimiter;
  logic              res_free;
  cst_res_t          res;

  cst_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .delimiter   (delimiter)
  );

  cst_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_text_byte (in_text_byte),
    .delimiter    (delimiter),
    .res_free     (res_free),
    .res          (res)
  );

  cst_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .res           (res),
    .res_free      (res_free),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_kind      (out_kind),
    .out_cell_byte (out_cell_byte),
    .out_drop_row  (out_drop_row)
  );

endmodule
`default_nettype wire

// File: design/cst_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_cfg
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module cst_cfg
  import cst_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready,
  output logic      [BYTE_W-1:0]     delimiter
);

  logic              wr_en;
  logic              sel_delim;
  logic [BYTE_W-1:0] delim_r;
  logic [BYTE_W-1:0] delim_nxt;

  assign cfg_pready = 1'b1;
  assign sel_delim  = (cfg_paddr[CFG_ADDR_W-1] == REG_DELIMITER);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    delim_nxt = delim_r;
    if (wr_en && sel_delim) begin
      delim_nxt = cfg_pwdata[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= DELIM_RESET;
    end else begin
      delim_r <= delim_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (sel_delim) begin
      cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, delim_r};
    end
  end

  assign delimiter = delim_r;

endmodule
`default_nettype wire

// File: design/cst_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_core
// input register, quote and cell state, and the per-byte decode
// ----------------------------------------------------------------------------
module cst_core
  import cst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire cst_cmd_t          in_cmd,
  input  wire logic [BYTE_W-1:0] in_text_byte,
  input  wire logic [BYTE_W-1:0] delimiter,
  input  wire logic              res_free,
  output cst_res_t               res
);

  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic cell_begun;
    logic cell_has_bytes;
    logic cell_has_nonspace;
    logic row_has_delimiter;
  } cst_state_t;

  logic              in_vld_r;
  logic              in_vld_nxt;
  cst_cmd_t          in_cmd_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              advance;
  logic              take;
  cst_state_t        st_r;
  cst_state_t        st_nxt;
  cst_state_t        st_upd;
  cst_res_t          res_c;

  function automatic logic is_space(input logic [BYTE_W-1:0] b);
    is_space = (b == 8'h20) || (b inside {[8'h09:8'h0D]});
  endfunction

  // decode of the held item
  always_comb begin
    logic              unq;
    logic [BYTE_W-1:0] c;
    c      = in_byte_r;
    unq    = 1'b0;
    st_upd = st_r;
    res_c  = '{valid: 1'b0, kind: KIND_BYTE, cell_byte: '0, drop_row: 1'b0};
    if (in_cmd_r == CMD_END) begin
      if (st_r.cell_has_bytes || st_r.row_has_delimiter) begin
        res_c.valid    = 1'b1;
        res_c.kind     = KIND_ROW_END;
        res_c.drop_row = !st_r.row_has_delimiter && !st_r.cell_has_nonspace;
      end
      st_upd = '0;
    end else begin
      if (st_r.quote_pending) begin
        st_upd.quote_pending = 1'b0;
        if (c == QUOTE_BYTE) begin
          res_c.valid                = 1'b1;
          res_c.cell_byte            = QUOTE_BYTE;
          st_upd.cell_has_bytes      = 1'b1;
          st_upd.cell_has_nonspace   = 1'b1;
        end else begin
          st_upd.in_quotes = 1'b0;
          unq              = 1'b1;
        end
      end else if (st_r.in_quotes) begin
        if (c == QUOTE_BYTE) begin
          st_upd.quote_pending = 1'b1;
        end else begin
          res_c.valid           = 1'b1;
          res_c.cell_byte       = c;
          st_upd.cell_has_bytes = 1'b1;
          if (!is_space(c)) begin
            st_upd.cell_has_nonspace = 1'b1;
          end
        end
      end else begin
        unq = 1'b1;
      end

      if (unq) begin
        if (c == QUOTE_BYTE && !st_r.cell_begun) begin
          st_upd.in_quotes  = 1'b1;
          st_upd.cell_begun = 1'b1;
        end else if (c == delimiter) begin
          st_upd.cell_begun        = 1'b0;
          st_upd.cell_has_bytes    = 1'b0;
          st_upd.cell_has_nonspace = 1'b0;
          st_upd.row_has_delimiter = 1'b1;
          res_c.valid              = 1'b1;
          res_c.kind               = KIND_CELL_END;
        end else if (c == CR_BYTE) begin
          // carriage return outside quotes is dropped
        end else if (c == LF_BYTE) begin
          res_c.valid              = 1'b1;
          res_c.kind               = KIND_ROW_END;
          res_c.drop_row           = !st_r.row_has_delimiter && !st_r.cell_has_nonspace;
          st_upd.cell_begun        = 1'b0;
          st_upd.cell_has_bytes    = 1'b0;
          st_upd.cell_has_nonspace = 1'b0;
          st_upd.row_has_delimiter = 1'b0;
        end else begin
          res_c.valid           = 1'b1;
          res_c.cell_byte       = c;
          st_upd.cell_begun     = 1'b1;
          st_upd.cell_has_bytes = 1'b1;
          if (!is_space(c)) begin
            st_upd.cell_has_nonspace = 1'b1;
          end
        end
      end
    end
  end

  assign advance  = in_vld_r && (!res_c.valid || res_free);
  assign in_stall = in_vld_r && !advance;
  assign take     = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    st_nxt     = st_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
      st_nxt     = st_upd;
    end
    if (take) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      st_r     <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      st_r     <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_cmd_r  <= in_cmd;
      in_byte_r <= in_text_byte;
    end
  end

  always_comb begin
    res       = res_c;
    res.valid = advance && res_c.valid;
  end

endmodule
`default_nettype wire

// File: design/cst_out_reg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_out_reg
// result register in front of the output channel
// ----------------------------------------------------------------------------
module cst_out_reg
  import cst_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cst_res_t          res,
  output logic                   res_free,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output cst_kind_t              out_kind,
  output logic      [BYTE_W-1:0] out_cell_byte,
  output logic                   out_drop_row
);

  logic              vld_r;
  logic              vld_nxt;
  cst_kind_t         kind_r;
  logic [BYTE_W-1:0] byte_r;
  logic              drop_r;

  assign res_free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (res_free) begin
      vld_nxt = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res.valid) begin
      kind_r <= res.kind;
      byte_r <= res.cell_byte;
      drop_r <= res.drop_row;
    end
  end

  assign out_valid     = vld_r;
  assign out_kind      = kind_r;
  assign out_cell_byte = byte_r;
  assign out_drop_row  = drop_r;

endmodule
`default_nettype wire

// File: design/cst_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cst_checker
// port-level checks on the tokenizer, bound to the top level
// ----------------------------------------------------------------------------
module cst_checker
  import cst_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire cst_kind_t         out_kind,
  input wire logic [BYTE_W-1:0] out_cell_byte,
  input wire logic              out_drop_row
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_cell_byte) && $stable(out_drop_row))
    else $error("stalled result changed");

  // no kind code beyond row end
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == KIND_BYTE || out_kind == KIND_CELL_END ||
      out_kind == KIND_ROW_END))
    else $error("undefined token kind");

  // marks carry no byte, only row ends may carry the drop flag
  a_mark_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != KIND_BYTE |->
      out_cell_byte == '0 && (out_drop_row == 1'b0 || out_kind == KIND_ROW_END))
    else $error("token mark carries payload");

  // input side is never stalled while the result register is empty
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind csv_stream_tokenizer cst_checker u_cst_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_kind      (out_kind),
  .out_cell_byte (out_cell_byte),
  .out_drop_row  (out_drop_row)
);
`default_nettype wire
